### hw/rtl/itda_pkg.sv
// Shared types and character constants for the integer to decimal text converter.
`timescale 1ns / 1ps

package itda_pkg;

   // Character and count field widths on the result channel
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 4;

   // ASCII codes used by the converter
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

endpackage

### hw/rtl/int_to_decimal_ascii_top.sv
// Signed integer to decimal ASCII converter, shift-and-add-3 sequencer, one character a beat.
// Flow: conversion of the magnitude, then leading-zero skip, then one character
//   per cycle while the output register is free to take it.
// A new number is taken only once the last character of the previous one is loaded,
//   as the single BCD adjust-and-shift unit works on one number, one magnitude bit a cycle.
// Reset: synchronous, active high; returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps

module int_to_decimal_ascii_top
   import itda_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: value [DATA_WIDTH-1:0], zero padding above
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: char_code [7:0], char_count [11:8], zero padding [15:12]
   output logic [15:0]                         rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready
);

   // Decimal digits needed for a DATA_WIDTH-bit magnitude (1233/4096 ~ log10 2)
   localparam int NDIG  = (DATA_WIDTH * 1233) / 4096 + 1;
   localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int BIT_W = $clog2(DATA_WIDTH);
   localparam int CNT_W = $clog2(NDIG + 2);
   localparam int TOT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   state_type               state_ff, state_in;
   logic [DATA_WIDTH-1:0]   mag_ff, mag_in;
   logic [3:0]              bcd_ff [NDIG];
   logic [3:0]              bcd_in [NDIG];
   logic [3:0]              adj    [NDIG];
   logic [BIT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        lead_ff, lead_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [DATA_WIDTH-1:0]   value;
   logic                    out_free;
   logic [3:0]              cur_digit;
   logic                    idx_zero;
   logic [TOT_W-1:0]        total;

   // Sequencer controls
   logic                    do_load;
   logic                    do_shift;
   logic                    do_dec;
   logic                    do_mark;
   logic                    emit_sign;
   logic                    emit_digit;

   assign value     = req_tdata[DATA_WIDTH-1:0];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cur_digit = bcd_ff[idx_ff];
   assign idx_zero  = (idx_ff == '0);
   // digits from the leading one down to the units, plus the sign
   assign total     = TOT_W'(lead_ff) + TOT_W'(neg_ff) + TOT_W'(1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (cur_digit != 4'd0 || idx_zero) state_in = neg_ff ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            if (out_free) state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (out_free && idx_zero) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      do_load    = 1'b0;
      do_shift   = 1'b0;
      do_dec     = 1'b0;
      do_mark    = 1'b0;
      emit_sign  = 1'b0;
      emit_digit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            do_load    = req_tvalid;
         end
         ST_CONVERT: begin
            do_shift = 1'b1;
         end
         ST_SKIP: begin
            do_dec  = (cur_digit == 4'd0) && !idx_zero;
            do_mark = 1'b1;
         end
         ST_SIGN: begin
            emit_sign = out_free;
         end
         ST_DIGITS: begin
            emit_digit = out_free;
            do_dec     = out_free && !idx_zero;
         end
         default: ;
      endcase
   end

   // Add-3 correction on every BCD digit ahead of the shift
   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   // Datapath next values
   always_comb begin
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      idx_in       = idx_ff;
      lead_in      = lead_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      for (int i = 0; i < NDIG; i++) bcd_in[i] = bcd_ff[i];

      if (do_load) begin
         // unsigned magnitude of the same width: the most negative value maps to 2^(W-1)
         neg_in     = value[DATA_WIDTH-1];
         mag_in     = value[DATA_WIDTH-1] ? (~value + DATA_WIDTH'(1)) : value;
         bit_cnt_in = BIT_W'(DATA_WIDTH - 1);
         idx_in     = IDX_W'(NDIG - 1);
         for (int i = 0; i < NDIG; i++) bcd_in[i] = 4'd0;
      end

      if (do_shift) begin
         bcd_in[0] = {adj[0][2:0], mag_ff[DATA_WIDTH-1]};
         for (int i = 1; i < NDIG; i++) bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
         mag_in     = {mag_ff[DATA_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BIT_W'(1);
      end

      if (do_dec) idx_in = idx_ff - IDX_W'(1);

      // the last skip cycle leaves the leading digit position here
      if (do_mark) lead_in = idx_ff;

      // output register: load a new beat or drain the taken one
      if (emit_sign) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_MINUS;
         rsp_count_in = '0;
         rsp_last_in  = 1'b0;
      end else if (emit_digit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_ZERO + CHAR_W'(cur_digit);
         rsp_count_in = idx_zero ? total[COUNT_W-1:0] : '0;
         rsp_last_in  = idx_zero;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff       <= mag_in;
      bit_cnt_ff   <= bit_cnt_in;
      idx_ff       <= idx_in;
      lead_ff      <= lead_in;
      neg_ff       <= neg_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      for (int i = 0; i < NDIG; i++) bcd_ff[i] <= bcd_in[i];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_char_ff};

   // Checks
   a_last_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[11:8] != 4'd0 || NDIG > 14)
      else $error("final character without a count");

   a_mid_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[11:8] == 4'd0)
      else $error("count on a non-final character");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CONVERT)
      else $error("accepted beat did not start conversion");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGITS |-> cur_digit <= 4'd9)
      else $error("BCD digit out of range");

   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("sign emitted for a positive value");

endmodule
